[src/bfe_pkg.sv]
// Package: shared constants, types and helpers for the bitfield engine.
package bfe_pkg;

  localparam int unsigned StoreWordsDef   = 512;
  localparam int unsigned MaxFieldBitsDef = 64;
  localparam logic [12:0] MaxBytesReset   = 13'd4096;

  typedef enum logic [1:0] {
    ActGet  = 2'd0,
    ActSet  = 2'd1,
    ActIncr = 2'd2,
    ActRsvd = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StOvfl   = 2'd1,
    StRange  = 2'd2,
    StBadTyp = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OvWrap = 2'd0,
    OvSat  = 2'd1,
    OvFail = 2'd2,
    OvRsvd = 2'd3
  } ovfl_e;

  // Sign- or zero-extend the low bits of a value to 64 bits.
  function automatic logic [63:0] ext_field(input logic [63:0] v, input logic [6:0] bits,
                                            input logic sgn);
    logic [63:0] mask;
    logic [63:0] r;
    mask = (bits >= 7'd64) ? '1 : ((64'd1 << bits[5:0]) - 64'd1);
    r = v & mask;
    if (sgn && bits < 7'd64 && bits != 7'd0 && r[bits[5:0] - 6'd1]) r = r | ~mask;
    return r;
  endfunction

endpackage

[src/bfe_alu.sv]
// Datapath: overflow judgment and new field value for SET and INCRBY.
module bfe_alu (
  input  logic [1:0]  action_i,
  input  logic        is_signed_i,
  input  logic [6:0]  field_bits_i,
  input  logic [1:0]  overflow_mode_i,
  input  logic [63:0] old_i,
  input  logic [63:0] operand_i,
  output logic [63:0] new_o,
  output logic        write_o,
  output logic        fail_o
);
  logic [63:0] v, inc, sum, mask, smax, ncmp;
  logic        vneg, ineg, sneg, up, dn, modify;
  logic [1:0]  mode;

  always_comb begin
    modify = (action_i == bfe_pkg::ActSet || action_i == bfe_pkg::ActIncr);
    mask = (field_bits_i >= 7'd64) ? '1 : ((64'd1 << field_bits_i[5:0]) - 64'd1);
    smax = mask >> 1;
    v    = (action_i == bfe_pkg::ActSet) ? operand_i : old_i;
    inc  = (action_i == bfe_pkg::ActSet) ? 64'd0 : operand_i;
    sum  = v + inc;
    vneg = v[63];
    ineg = inc[63];
    sneg = sum[63];
    up   = 1'b0;
    dn   = 1'b0;
    ncmp = ~sum;
    if (is_signed_i) begin
      if (vneg == ineg && sneg != vneg) begin
        up = !vneg;
        dn = vneg;
      end else if (field_bits_i < 7'd64) begin
        if (!sneg && (sum >> (field_bits_i - 7'd1)) != 64'd0) up = 1'b1;
        else if (sneg && (ncmp >> (field_bits_i - 7'd1)) != 64'd0) dn = 1'b1;
      end
    end else begin
      if (v > mask || (!ineg && inc != 64'd0 && inc > mask - v)) up = 1'b1;
      else if (ineg && (64'd0 - inc) > v) dn = 1'b1;
    end
    mode   = overflow_mode_i;
    // reads never fail, only SET and INCRBY judge overflow
    fail_o = (up || dn) && mode == bfe_pkg::OvFail && modify;
    if (!(up || dn)) new_o = sum;
    else if (mode == bfe_pkg::OvWrap) new_o = bfe_pkg::ext_field(sum, field_bits_i, is_signed_i);
    else if (is_signed_i) new_o = up ? smax : ~smax;
    else new_o = up ? mask : 64'd0;
    write_o = modify && !fail_o;
  end
endmodule

[src/bfe_mem.sv]
// Word store: one synchronous read port, one write port, zeroed by a clearing pass after reset.
module bfe_mem #(
  parameter int unsigned Words = bfe_pkg::StoreWordsDef,
  localparam int unsigned AW = (Words > 1) ? $clog2(Words) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          clr_busy_o,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i
);
  logic [63:0]   mem [Words];
  logic [63:0]   rd_q;
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i) begin
    if (clr_q) mem[clr_addr_q] <= 64'd0;
    else if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

  // one word per cycle, addresses 0 to Words-1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(Words - 1)) clr_q <= 1'b0;
    end
  end

  assign clr_busy_o = clr_q;
  assign rd_data_o  = rd_q;
endmodule

[src/bitfield_get_set_incr_engine_top.sv]
// Top level: bitfield GET/SET/INCRBY engine over a bit-addressed word store.
// Each item reads one field of 1..64 bits (MSB first, at most 63 bits when
// unsigned) that may straddle two 64-bit words of a synchronous store (one
// read port, one write port, registered read), computes the result, and for
// SET and INCRBY that do not fail writes the touched words back. The steps
// are a check state, one read per word, extraction of the old field, the
// computation, and one write-back state per word. Rejected items (bad type,
// offset out of range) go from the check state straight to the result. One
// item is in flight at a time, so no forwarding is needed; once the result
// is taken the engine returns to idle before the next accept.
// Reset starts a clearing pass that zeroes the store one word per cycle,
// all StoreWords words (512 by default), during which no item is accepted.
// Bits past the store read zero, writes there are dropped. The result sits in
// an output register until taken.
module bitfield_get_set_incr_engine_top #(
  parameter int unsigned StoreWords   = bfe_pkg::StoreWordsDef,
  parameter int unsigned MaxFieldBits = bfe_pkg::MaxFieldBitsDef,
  localparam int unsigned AW = (StoreWords > 1) ? $clog2(StoreWords) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_max_bytes_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        is_signed_i,
  input  logic [6:0]  field_bits_i,
  input  logic [31:0] bit_offset_i,
  input  logic        offset_in_fields_i,
  input  logic [63:0] operand_value_i,
  input  logic [1:0]  overflow_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_value_o,
  output logic [1:0]  status_o
);
  typedef enum logic [8:0] {
    SIdle  = 9'b0_0000_0001,
    SChk   = 9'b0_0000_0010,
    SRd0   = 9'b0_0000_0100,
    SRd1   = 9'b0_0000_1000,
    SExt   = 9'b0_0001_0000,
    SCalc  = 9'b0_0010_0000,
    SWr0   = 9'b0_0100_0000,
    SWr1   = 9'b0_1000_0000,
    SOut   = 9'b1_0000_0000
  } state_e;

  state_e      state_q, state_d;
  logic [12:0] max_bytes_q;
  logic [1:0]  act_q, mode_q;
  logic        sgn_q;
  logic [6:0]  bits_q;
  logic [63:0] opnd_q;
  logic [38:0] off_q;       // bit offset after scaling
  logic [63:0] w0_q, w1_q;  // raw words around the field
  logic [63:0] old_q, new_q;
  logic        wr_q;
  logic [63:0] res_q;
  logic [1:0]  st_q;

  // Word addressing of the field.
  logic [32:0] widx0, widx1;
  logic [5:0]  bpos;
  logic        two_w, in0, in1;
  assign widx0 = off_q[38:6];
  assign widx1 = widx0 + 33'd1;
  assign bpos  = off_q[5:0];
  assign two_w = ({1'b0, bpos} + bits_q) > 7'd64;
  assign in0   = widx0 < 33'(StoreWords);
  assign in1   = widx1 < 33'(StoreWords);

  // Field extract: 128-bit window, MSB first.
  logic [127:0] win, wmask, wnew;
  logic [63:0]  raw, fmask;
  logic [6:0]   shr;
  always_comb begin
    win   = {w0_q, w1_q};
    shr   = 7'd64 - bits_q;
    fmask = (bits_q >= 7'd64) ? '1 : ((64'd1 << bits_q[5:0]) - 64'd1);
    raw   = 64'((win << bpos) >> (7'd64 + shr));
    wmask = ({fmask, 64'd0} << shr) >> bpos;
    wnew  = ({new_q & fmask, 64'd0} << shr) >> bpos;
  end

  logic [63:0] alu_new;
  logic        alu_wr, alu_fail;
  bfe_alu u_alu (
    .action_i(act_q), .is_signed_i(sgn_q), .field_bits_i(bits_q),
    .overflow_mode_i(mode_q), .old_i(old_q), .operand_i(opnd_q),
    .new_o(alu_new), .write_o(alu_wr), .fail_o(alu_fail)
  );

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   rd_data, wr_data;
  logic          rd_pend_q;
  logic          rd_sel_q;
  logic          clr_busy;

  bfe_mem #(.Words(StoreWords)) u_mem (
    .clk_i, .rst_ni, .clr_busy_o(clr_busy),
    .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  function automatic logic field_bits_q_bad(input logic [6:0] b, input logic s);
    return b == 7'd0 || b > 7'(MaxFieldBits) || (!s && b > 7'd63);
  endfunction

  logic type_bad;
  assign type_bad = field_bits_q_bad(bits_q, sgn_q);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == SIdle) && !clr_busy;
  assign out_valid_o = (state_q == SOut);
  assign result_value_o = res_q;
  assign status_o    = st_q;

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = AW'(widx0);
    wr_en   = 1'b0;
    wr_addr = AW'(widx0);
    wr_data = (w0_q & ~wmask[127:64]) | wnew[127:64];
    unique case (state_q)
      SIdle: if (in_valid_i && in_ready_o) state_d = SChk;
      SChk: begin
        if (type_bad || max_bytes_q == 13'd0 || off_q[38:3] >= 36'(max_bytes_q)) begin
          state_d = SOut;
        end else begin
          rd_en   = in0;
          state_d = two_w ? SRd1 : SRd0;
        end
      end
      SRd1: begin
        rd_en   = in1;
        rd_addr = AW'(widx1);
        state_d = SRd0;
      end
      SRd0: state_d = SExt;
      SExt: state_d = SCalc;
      SCalc: state_d = SWr0;
      SWr0: begin
        wr_en   = wr_q && in0;
        state_d = two_w ? SWr1 : SOut;
      end
      SWr1: begin
        wr_en   = wr_q && in1;
        wr_addr = AW'(widx1);
        wr_data = (w1_q & ~wmask[63:0]) | wnew[63:0];
        state_d = SOut;
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      max_bytes_q <= bfe_pkg::MaxBytesReset;
      rd_pend_q   <= 1'b0;
      rd_sel_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) max_bytes_q <= cfg_max_bytes_i;
      rd_pend_q <= rd_en;
      rd_sel_q  <= (state_q == SRd1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_i;
      sgn_q  <= is_signed_i;
      bits_q <= field_bits_i;
      off_q  <= offset_in_fields_i ? 39'(bit_offset_i) * 39'(field_bits_i)
                                   : 39'(bit_offset_i);
      opnd_q <= operand_value_i;
      mode_q <= overflow_mode_i;
    end
    if (state_q == SChk) begin
      w0_q  <= 64'd0;
      w1_q  <= 64'd0;
    end
    if (rd_pend_q) begin
      if (rd_sel_q) w1_q <= rd_data;
      else w0_q <= rd_data;
    end
    if (state_q == SCalc) begin
      new_q <= alu_new;
      wr_q  <= alu_wr;
    end
    if (state_q == SChk) begin
      res_q <= 64'd0;
      if (type_bad) st_q <= bfe_pkg::StBadTyp;
      else st_q <= bfe_pkg::StRange;
    end
    if (state_q == SCalc) begin
      if (alu_fail) begin
        st_q  <= bfe_pkg::StOvfl;
        res_q <= 64'd0;
      end else begin
        st_q  <= bfe_pkg::StOk;
        res_q <= (act_q == bfe_pkg::ActSet) ? old_q
               : (act_q == bfe_pkg::ActIncr) ? alu_new : old_q;
      end
    end
  end

  // old_q follows the words every cycle; the value loaded in SExt, once both words have landed, is used.
  always_ff @(posedge clk_i) begin
    old_q <= bfe_pkg::ext_field(raw, bits_q, sgn_q);
  end

  // Assertions.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("result dropped while stalled");
  a_no_wr_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> st_q == bfe_pkg::StOk)
    else $error("write on failed item");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o && !wr_en)
    else $error("accept while busy");
endmodule
